>>> hw/rtl/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types and constants of the bucketed hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package bht_pkg;

	localparam int BUCKET_BITS = 8;
	localparam int WAYS        = 4;
	localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
	localparam int NUM_SLOTS   = NUM_BUCKETS * WAYS;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 11;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_ERASE  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_MISS     = 3'd3,
		ST_RESERVED = 3'd4
	} status_e;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_BUSY = 2'd1,
		FSM_WIPE = 2'd2
	} fsm_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture request, read bucket row
		logic commit;  // update table, load result register
		logic wipe;    // zero one valid-bit row, advance the wipe index
	} bht_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic clear;      // word in the compare stage is a clear
		logic wipe_last;  // wipe index sits on the last bucket
	} bht_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/bht_if.sv
// ----------------------------------------------------------------------------
// bht_req_if / bht_rsp_if
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bht_req_if import bht_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value_in;

	modport source (output valid, output cmd, output key, output value_in, input ready);
	modport sink   (input valid, input cmd, input key, input value_in, output ready);
endinterface

interface bht_rsp_if import bht_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                hit;
	logic [VAL_W-1:0]    value_out;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output hit, output value_out, output status,
		output entry_count, input ready);
	modport sink   (input valid, input hit, input value_out, input status,
		input entry_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bht_ctrl.sv
// ----------------------------------------------------------------------------
// bht_ctrl
// Sequencer: accept a word, commit it once the response register is free,
// and run the valid-bit clearing pass after reset and after a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bht_ctrl import bht_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	input  wire bht_sts_t sts,
	output bht_ctl_t      ctl
);

	fsm_state_t state_q, state_d;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (req_valid) state_d = FSM_BUSY;
			end
			FSM_BUSY: begin
				if (rsp_free) state_d = sts.clear ? FSM_WIPE : FSM_IDLE;
			end
			FSM_WIPE: begin
				if (sts.wipe_last) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		ctl.load   = 1'b0;
		ctl.commit = 1'b0;
		ctl.wipe   = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_ready = 1'b1;
				ctl.load  = req_valid;
			end
			FSM_BUSY: begin
				ctl.commit = rsp_free;
			end
			FSM_WIPE: begin
				ctl.wipe = 1'b1;
			end
			default: ;
		endcase
	end

	// reset lands in the wipe pass so the valid bits start out zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_WIPE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit)     rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/bht_dp.sv
// ----------------------------------------------------------------------------
// bht_dp
// Bucket memories, valid-bit memory, way compare and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bht_dp import bht_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bht_ctl_t            ctl,
	input  wire logic [CMD_W-1:0]    req_cmd,
	input  wire logic [KEY_W-1:0]    req_key,
	input  wire logic [VAL_W-1:0]    req_value,
	output bht_sts_t                 sts,
	output logic                     rsp_hit,
	output logic [VAL_W-1:0]         rsp_value,
	output logic [STATUS_W-1:0]      rsp_status,
	output logic [COUNT_W-1:0]       rsp_count
);

	// one row per bucket; key and value rows are written one way at a time
	logic [WAYS-1:0][KEY_W-1:0] key_mem [NUM_BUCKETS];
	logic [WAYS-1:0][VAL_W-1:0] val_mem [NUM_BUCKETS];
	logic [WAYS-1:0]            valid_mem [NUM_BUCKETS];
	logic [COUNT_W-1:0]         occupied_q;
	logic [BUCKET_BITS-1:0]     wipe_idx_q;

	logic [WAYS-1:0][KEY_W-1:0] key_row_q;
	logic [WAYS-1:0][VAL_W-1:0] val_row_q;
	logic [WAYS-1:0]            valid_row_q;
	cmd_e                       cmd_q;
	logic [KEY_W-1:0]           key_q;
	logic [VAL_W-1:0]           value_q;

	logic                       hit_q;
	logic [VAL_W-1:0]           vout_q;
	status_e                    status_q;

	logic [BUCKET_BITS-1:0]     bucket;
	logic [WAYS-1:0]            row_valid;
	logic [WAYS-1:0]            valid_new;
	logic [WAYS-1:0]            match;
	logic                       found;
	logic [WAY_W-1:0]           match_way;
	logic                       has_free;
	logic [WAY_W-1:0]           free_way;

	logic                       hit_d;
	logic [VAL_W-1:0]           vout_d;
	status_e                    status_d;
	logic [COUNT_W-1:0]         count_d;
	logic                       do_insert;
	logic                       do_erase;
	logic                       do_clear;

	assign bucket    = key_q[BUCKET_BITS-1:0];
	assign row_valid = valid_row_q;

	assign sts.clear     = do_clear;
	assign sts.wipe_last = (wipe_idx_q == '1);

	always_comb begin
		match     = '0;
		found     = 1'b0;
		match_way = '0;
		has_free  = 1'b0;
		free_way  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = row_valid[w] && (key_row_q[w] == key_q);
			if (match[w]) begin
				found     = 1'b1;
				match_way = WAY_W'(w);
			end
			if (!row_valid[w]) begin
				has_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		hit_d     = 1'b0;
		vout_d    = '0;
		status_d  = ST_OK;
		count_d   = occupied_q;
		do_insert = 1'b0;
		do_erase  = 1'b0;
		do_clear  = 1'b0;
		if (cmd_q == CMD_CLEAR) begin
			do_clear = 1'b1;
			count_d  = '0;
		end else if (key_q == '0) begin
			status_d = ST_RESERVED;
		end else begin
			case (cmd_q)
				CMD_INSERT: begin
					if (found) status_d = ST_DUP;
					else if (!has_free) status_d = ST_FULL;
					else begin
						do_insert = 1'b1;
						hit_d     = 1'b1;
						count_d   = occupied_q + COUNT_W'(1);
					end
				end
				CMD_LOOKUP: begin
					if (found) begin
						hit_d  = 1'b1;
						vout_d = val_row_q[match_way];
					end else status_d = ST_MISS;
				end
				CMD_ERASE: begin
					if (found) begin
						do_erase = 1'b1;
						hit_d    = 1'b1;
						if (occupied_q != '0) count_d = occupied_q - COUNT_W'(1);
					end else status_d = ST_MISS;
				end
				default: ;
			endcase
		end
	end

	// updated valid row for the bucket under compare
	always_comb begin
		valid_new = row_valid;
		if (do_insert) valid_new[free_way] = 1'b1;
		if (do_erase)  valid_new[match_way] = 1'b0;
	end

	// request capture and bucket row read
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q       <= cmd_e'(req_cmd);
			key_q       <= req_key;
			value_q     <= req_value;
			key_row_q   <= key_mem[req_key[BUCKET_BITS-1:0]];
			val_row_q   <= val_mem[req_key[BUCKET_BITS-1:0]];
			valid_row_q <= valid_mem[req_key[BUCKET_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && do_insert) begin
			key_mem[bucket][free_way] <= key_q;
			val_mem[bucket][free_way] <= value_q;
		end
	end

	// valid bits: one row a cycle, from the wipe pass or from a commit
	always_ff @(posedge clk) begin
		if (ctl.wipe) begin
			valid_mem[wipe_idx_q] <= '0;
		end else if (ctl.commit && (do_insert || do_erase)) begin
			valid_mem[bucket] <= valid_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			hit_q    <= hit_d;
			vout_q   <= vout_d;
			status_q <= status_d;
		end
	end

	// wipe index wraps back to zero at the end of each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= '0;
			wipe_idx_q <= '0;
		end else begin
			if (ctl.commit) occupied_q <= count_d;
			if (ctl.wipe)   wipe_idx_q <= wipe_idx_q + BUCKET_BITS'(1);
		end
	end

	assign rsp_hit    = hit_q;
	assign rsp_value  = vout_q;
	assign rsp_status = status_q;
	assign rsp_count  = occupied_q;

endmodule

`default_nettype wire

>>> hw/rtl/bucketed_hash_table.sv
// ----------------------------------------------------------------------------
// bucketed_hash_table
// Fixed-size four-way bucketed key/value table with insert, lookup, erase
// and clear.
// ----------------------------------------------------------------------------
// A key picks one of 256 buckets by its low 8 bits; each bucket holds four
// key/value slots tracked by valid bits, so every key value except zero can
// be stored (zero is reserved and answered with the reserved-key status).
// Every request word gives exactly one response word. On accept, the
// bucket's key, value and valid rows are read from the bucket memories
// into registers; at commit the four ways are compared, written back and
// the response register is loaded. The response is valid the cycle after
// the commit, when the request side is ready again (but for a clear), so
// a new word is never accepted before the last one has committed. While
// the response register is still full, a newly accepted word holds in the
// compare stage until the waiting response is taken. The valid bits live
// in a 256-row memory that a clearing pass zeroes one bucket per cycle,
// with the request side not ready: once right after reset, and after
// every clear. A clear returns its response (count zero) before its pass
// starts. There is no rehash: an insert into a full bucket answers bucket
// full. entry_count is the slot count after the operation.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_hash_table import bht_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bht_req_if.sink    req,
	bht_rsp_if.source  rsp
);

	bht_ctl_t ctl;
	bht_sts_t sts;

	// sequencer: accept, commit when the response register is free, wipe
	bht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// table storage, compare and response payload
	bht_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.req_cmd    (req.cmd),
		.req_key    (req.key),
		.req_value  (req.value_in),
		.sts        (sts),
		.rsp_hit    (rsp.hit),
		.rsp_value  (rsp.value_out),
		.rsp_status (rsp.status),
		.rsp_count  (rsp.entry_count)
	);

	// a commit always leaves a response word behind
	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> rsp.valid)
		else $error("commit without response");

	// one word in flight: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("back-to-back accept");

	// load and commit never coincide
	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.commit))
		else $error("load and commit together");

	// count never exceeds table capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.entry_count <= COUNT_W'(NUM_SLOTS)))
		else $error("entry count overflow");

endmodule

`default_nettype wire
